FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ITF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ITF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/itf_pkg.sv
`default_nettype none
package itf_pkg;

  localparam int WINDOW_LENGTH_DEF = 5;
  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int CORDIC_MAX_STEPS  = 24;

  localparam int CW     = 36;
  localparam int ZW     = 26;
  localparam int MUL_AW = 36;
  localparam int MUL_BW = 25;
  localparam int PW     = MUL_AW + MUL_BW;
  localparam int ACC_W  = PW + 1;

  localparam logic [16:0] INV_GAIN_Q16 = 17'd39797;
  localparam logic [16:0] ALPHA_ONE    = 17'd65536;

  localparam logic [2:0] CFG_ACCEL_SMOOTHING = 3'd0;
  localparam logic [2:0] CFG_GYRO_SMOOTHING  = 3'd1;
  localparam logic [2:0] CFG_YAW_STEP        = 3'd2;
  localparam logic [2:0] CFG_ACCEL_GAIN      = 3'd3;
  localparam logic [2:0] CFG_GYRO_GAIN       = 3'd4;

  localparam logic [16:0] ACCEL_SMOOTHING_RST = 17'd6554;
  localparam logic [16:0] GYRO_SMOOTHING_RST  = 17'd6554;
  localparam logic [15:0] YAW_STEP_RST        = 16'd655;
  localparam logic [23:0] ACCEL_GAIN_RST      = 24'd10045;
  localparam logic [15:0] GYRO_GAIN_RST       = 16'd256;

  // Arctangent of 2^-i in 1/65536 degree.
  localparam logic [21:0] ATAN_Q16 [CORDIC_MAX_STEPS] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
    22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
  };

endpackage
`default_nettype wire

FILE: hw/rtl/imu_tilt_and_heading_filter.sv
`default_nettype none
// One request of six raw sensor words gives one result. The block is busy from the
// accepted request until its result is loaded into the output register. It works the
// three accelerometer axes, then the three gyro axes, then the heading, then the two
// tilt angles. The CORDIC uses at most 24 steps per pass, whatever CORDIC_STEPS says,
// and a tilt whose vector is zero skips its second pass. The next request is taken
// once the block is back in idle. Most of the time goes to the four CORDIC vectoring
// passes, which run one step per cycle. All products share one registered multiplier,
// including the reciprocal division of each accelerometer mean by the window length.
// A result waiting in the output register does not hold off the next request, only
// the loading of the result after it. The configuration port is always ready and
// should be written only while idle.
module imu_tilt_and_heading_filter
  import itf_pkg::*;
#(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
  parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire signed [15:0] accel_x,
  input  wire signed [15:0] accel_y,
  input  wire signed [15:0] accel_z,
  input  wire signed [15:0] gyro_x,
  input  wire signed [15:0] gyro_y,
  input  wire signed [15:0] gyro_z,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [15:0] accel_x_out,
  output logic signed [15:0] accel_y_out,
  output logic signed [15:0] accel_z_out,
  output logic signed [19:0] gyro_x_out,
  output logic signed [19:0] gyro_y_out,
  output logic signed [19:0] gyro_z_out,
  output logic signed [15:0] pitch_angle,
  output logic signed [15:0] roll_angle,
  output logic signed [31:0] yaw_angle,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire [2:0]         cfg_index,
  input  wire [23:0]        cfg_data
);

  `include "assert_macros.svh"

  localparam int POS_W  = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int SUM_W  = 16 + $clog2(WINDOW_LENGTH);
  localparam int DIV_W  = SUM_W + 16;
  localparam int RECIP_SH = DIV_W + $clog2(WINDOW_LENGTH);
  localparam logic [63:0] RECIP = ((64'd1 << RECIP_SH) + 64'(WINDOW_LENGTH - 1))
                                  / 64'(WINDOW_LENGTH);
  localparam logic [MUL_BW-1:0] RECIP_LO = {1'b0, RECIP[23:0]};
  localparam logic [MUL_BW-1:0] RECIP_HI = {1'b0, RECIP[47:24]};

  typedef enum logic [22:0] {
    S_IDLE  = 23'h000001,
    S_WIN   = 23'h000002,
    S_MMUL  = 23'h000004,
    S_DLOAD = 23'h000008,
    S_RLO   = 23'h000010,
    S_RHI   = 23'h000020,
    S_RSUM  = 23'h000040,
    S_DEND  = 23'h000080,
    S_EMA1  = 23'h000100,
    S_EMA2  = 23'h000200,
    S_EMA3  = 23'h000400,
    S_EMA4  = 23'h000800,
    S_GMUL  = 23'h001000,
    S_GWAIT = 23'h002000,
    S_YMUL  = 23'h004000,
    S_YADD  = 23'h008000,
    S_C1    = 23'h010000,
    S_C1W   = 23'h020000,
    S_TM    = 23'h040000,
    S_TR    = 23'h080000,
    S_C2W   = 23'h100000,
    S_TA    = 23'h200000,
    S_DONE  = 23'h400000
  } state_t;

  state_t state;

  logic [16:0] accel_smoothing, gyro_smoothing;
  logic [15:0] yaw_step, gyro_gain;
  logic [23:0] accel_gain;

  logic signed [15:0] win [3][WINDOW_LENGTH];
  logic signed [SUM_W-1:0] wsum [3];
  logic [POS_W-1:0] pos;
  logic signed [31:0] as [3];
  logic signed [31:0] gs [3];
  logic signed [31:0] yaw;
  logic signed [15:0] in_a [3];
  logic signed [15:0] in_g [3];
  logic signed [15:0] ang [2];

  logic [1:0] ax;
  logic gyro_ph, tsel, neg;
  logic [DIV_W-1:0] dq;
  logic [PW-1:0] rlo;
  logic signed [32:0] ema_x;
  logic signed [ACC_W-1:0] acc;

  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [PW-1:0] p;

  logic c_start, c_done;
  logic signed [CW-1:0] c_x0, c_y0, c_x;
  logic signed [ZW-1:0] c_z;

  logic [16:0] alpha_raw, alpha_eff;
  logic [17:0] alpha_rest;
  logic signed [31:0] ema_s;
  logic signed [32:0] tu, tv, tw, tabs;
  logic signed [PW-1:0] pabs, msum;
  logic signed [CW-1:0] m;
  logic [PW+24:0] rsum;
  logic signed [DIV_W:0] qs;
  logic signed [31:0] qsat;
  logic signed [ACC_W-1:0] esum;
  logic signed [PW-1:0] ysum;
  logic signed [34:0] ytot;
  logic signed [ZW-1:0] zr;
  logic signed [17:0] a18;
  logic [POS_W-1:0] pos_inc;

  function automatic logic signed [15:0] narrow_accel(input logic signed [31:0] s);
    logic signed [32:0] r;
    r = 33'(s) + 33'sd32;
    if (r[32:21] == '0 || r[32:21] == '1) return r[21:6];
    return r[32] ? 16'sh8000 : 16'sh7FFF;
  endfunction

  function automatic logic signed [19:0] narrow_gyro(input logic signed [31:0] s);
    logic signed [32:0] r;
    r = 33'(s) + 33'sd8;
    if (r[32:23] == '0 || r[32:23] == '1) return r[23:4];
    return r[32] ? 20'sh80000 : 20'sh7FFFF;
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign alpha_raw  = gyro_ph ? gyro_smoothing : accel_smoothing;
  assign alpha_eff  = alpha_raw[16] ? ALPHA_ONE : alpha_raw;
  assign alpha_rest = {1'b0, ALPHA_ONE} - {1'b0, alpha_eff};
  assign ema_s      = gyro_ph ? gs[ax] : as[ax];

  assign tu   = tsel ? 33'(as[1]) : 33'(as[0]);
  assign tv   = 33'(as[2]);
  assign tw   = tsel ? -33'(as[0]) : 33'(as[1]);
  assign tabs = tu[32] ? -tu : tu;

  assign pabs = p[PW-1] ? -p : p;
  assign msum = p + PW'(32768);
  assign m    = msum[16+CW-1:16];

  assign rsum = {1'b0, p, 24'b0} + (PW+25)'(rlo);

  assign qs   = neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
  assign qsat = (qs[DIV_W:31] == '0 || qs[DIV_W:31] == '1) ? qs[31:0]
              : (qs[DIV_W] ? 32'sh80000000 : 32'sh7FFFFFFF);

  assign esum = acc + ACC_W'(32768);
  assign ysum = p + PW'(32768);
  assign ytot = 35'(yaw) + 35'($signed(ysum[49:16]));
  assign zr   = c_z + ZW'(128);
  assign a18  = zr[ZW-1:8];
  assign pos_inc = (pos == POS_W'(WINDOW_LENGTH - 1)) ? '0 : pos + POS_W'(1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MMUL: begin
        mul_a = MUL_AW'(wsum[ax]);
        mul_b = MUL_BW'({1'b0, accel_gain});
      end
      S_RLO: begin
        mul_a = MUL_AW'(dq);
        mul_b = RECIP_LO;
      end
      S_RHI: begin
        mul_a = MUL_AW'(dq);
        mul_b = RECIP_HI;
      end
      S_EMA1: begin
        mul_a = MUL_AW'(ema_x);
        mul_b = MUL_BW'({1'b0, alpha_eff});
      end
      S_EMA2: begin
        mul_a = MUL_AW'(ema_s);
        mul_b = MUL_BW'(alpha_rest);
      end
      S_GMUL: begin
        mul_a = MUL_AW'(in_g[ax]);
        mul_b = MUL_BW'({1'b0, gyro_gain});
      end
      S_YMUL: begin
        mul_a = MUL_AW'(gs[2]);
        mul_b = MUL_BW'({1'b0, yaw_step});
      end
      S_TM: begin
        mul_a = c_x;
        mul_b = MUL_BW'(INV_GAIN_Q16);
      end
      default: ;
    endcase
  end

  assign c_start = (state == S_C1) || (state == S_TR && !(m == '0 && tw == '0));
  assign c_x0    = (state == S_C1) ? CW'(tabs) : m;
  assign c_y0    = (state == S_C1) ? CW'(tv) : CW'(tw);

  itf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  itf_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (c_start),
    .x0    (c_x0),
    .y0    (c_y0),
    .x     (c_x),
    .z     (c_z),
    .done  (c_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_smoothing <= ACCEL_SMOOTHING_RST;
      gyro_smoothing  <= GYRO_SMOOTHING_RST;
      yaw_step        <= YAW_STEP_RST;
      accel_gain      <= ACCEL_GAIN_RST;
      gyro_gain       <= GYRO_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ACCEL_SMOOTHING: accel_smoothing <= cfg_data[16:0];
        CFG_GYRO_SMOOTHING:  gyro_smoothing  <= cfg_data[16:0];
        CFG_YAW_STEP:        yaw_step        <= cfg_data[15:0];
        CFG_ACCEL_GAIN:      accel_gain      <= cfg_data;
        CFG_GYRO_GAIN:       gyro_gain       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pos       <= '0;
      yaw       <= '0;
      ax        <= '0;
      gyro_ph   <= 1'b0;
      tsel      <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        wsum[a] <= '0;
        as[a]   <= '0;
        gs[a]   <= '0;
        for (int k = 0; k < WINDOW_LENGTH; k++) begin
          win[a][k] <= '0;
        end
      end
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            in_a[0] <= accel_x;
            in_a[1] <= accel_y;
            in_a[2] <= accel_z;
            in_g[0] <= gyro_x;
            in_g[1] <= gyro_y;
            in_g[2] <= gyro_z;
            ax      <= '0;
            gyro_ph <= 1'b0;
            tsel    <= 1'b0;
            state   <= S_WIN;
          end
        end
        S_WIN: begin
          win[ax][pos] <= in_a[ax];
          wsum[ax] <= wsum[ax] + SUM_W'(in_a[ax]) - SUM_W'(win[ax][pos]);
          if (ax == 2'd2) begin
            pos <= pos_inc;
          end
          state <= S_MMUL;
        end
        S_MMUL: state <= S_DLOAD;
        S_DLOAD: begin
          neg   <= p[PW-1];
          dq    <= pabs[DIV_W+7:8];
          state <= S_RLO;
        end
        S_RLO: state <= S_RHI;
        S_RHI: begin
          rlo   <= p;
          state <= S_RSUM;
        end
        S_RSUM: begin
          dq    <= rsum[RECIP_SH +: DIV_W];
          state <= S_DEND;
        end
        S_DEND: begin
          ema_x <= 33'(qsat);
          state <= S_EMA1;
        end
        S_EMA1: state <= S_EMA2;
        S_EMA2: begin
          acc   <= ACC_W'(p);
          state <= S_EMA3;
        end
        S_EMA3: begin
          acc   <= acc + ACC_W'(p);
          state <= S_EMA4;
        end
        S_EMA4: begin
          if (gyro_ph) begin
            gs[ax] <= esum[47:16];
          end else begin
            as[ax] <= esum[47:16];
          end
          if (ax != 2'd2) begin
            ax    <= ax + 2'd1;
            state <= gyro_ph ? S_GMUL : S_WIN;
          end else if (!gyro_ph) begin
            ax      <= '0;
            gyro_ph <= 1'b1;
            state   <= S_GMUL;
          end else begin
            state <= S_YMUL;
          end
        end
        S_GMUL: state <= S_GWAIT;
        S_GWAIT: begin
          ema_x <= p[32:0];
          state <= S_EMA1;
        end
        S_YMUL: state <= S_YADD;
        S_YADD: begin
          if (ytot[34:31] == '0 || ytot[34:31] == '1) begin
            yaw <= ytot[31:0];
          end else begin
            yaw <= ytot[34] ? 32'sh80000000 : 32'sh7FFFFFFF;
          end
          state <= S_C1;
        end
        S_C1: state <= S_C1W;
        S_C1W: begin
          if (c_done) begin
            state <= S_TM;
          end
        end
        S_TM: state <= S_TR;
        S_TR: begin
          if (m == '0 && tw == '0) begin
            ang[tsel] <= '0;
            tsel      <= 1'b1;
            state     <= tsel ? S_DONE : S_C1;
          end else begin
            state <= S_C2W;
          end
        end
        S_C2W: begin
          if (c_done) begin
            state <= S_TA;
          end
        end
        S_TA: begin
          if (a18 > 18'sd23040) begin
            ang[tsel] <= 16'sd23040;
          end else if (a18 < -18'sd23040) begin
            ang[tsel] <= -16'sd23040;
          end else begin
            ang[tsel] <= a18[15:0];
          end
          tsel  <= 1'b1;
          state <= tsel ? S_DONE : S_C1;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            accel_x_out <= narrow_accel(as[0]);
            accel_y_out <= narrow_accel(as[1]);
            accel_z_out <= narrow_accel(as[2]);
            gyro_x_out  <= narrow_gyro(gs[0]);
            gyro_y_out  <= narrow_gyro(gs[1]);
            gyro_z_out  <= narrow_gyro(gs[2]);
            pitch_angle <= ang[0];
            roll_angle  <= ang[1];
            yaw_angle   <= yaw;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ITF_ASSERT(a_pos_range, pos <= POS_W'(WINDOW_LENGTH - 1), "Window position out of range")
  `ITF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(yaw_angle), "Stalled result changed")
  `ITF_ASSERT(a_tilt_range, out_valid |-> pitch_angle <= 16'sd23040 && pitch_angle >= -16'sd23040 && roll_angle <= 16'sd23040 && roll_angle >= -16'sd23040, "Tilt out of range")

endmodule
`default_nettype wire

FILE: hw/rtl/itf_mul.sv
`default_nettype none
module itf_mul
  import itf_pkg::*;
(
  input  wire                     clk,
  input  wire signed [MUL_AW-1:0] a,
  input  wire signed [MUL_BW-1:0] b,
  output logic signed [PW-1:0]    p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/itf_cordic.sv
`default_nettype none
module itf_cordic
  import itf_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire signed [CW-1:0] x0,
  input  wire signed [CW-1:0] y0,
  output logic signed [CW-1:0] x,
  output logic signed [ZW-1:0] z,
  output logic                done
);

  `include "assert_macros.svh"

  localparam int N  = (CORDIC_STEPS < CORDIC_MAX_STEPS) ? CORDIC_STEPS : CORDIC_MAX_STEPS;
  localparam int IW = $clog2(N);

  logic signed [CW-1:0] y;
  logic [IW-1:0] i;
  logic busy;
  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] da;

  assign dx = y >>> i;
  assign dy = x >>> i;
  assign da = ZW'(ATAN_Q16[5'(i)]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && i == IW'(N - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= x0;
      y <= y0;
      z <= '0;
      i <= '0;
    end else if (busy) begin
      if (!y[CW-1]) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + da;
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - da;
      end
      i <= i + IW'(1);
    end
  end

  `ITF_ASSERT(a_no_restart, start |-> !busy, "CORDIC restarted while busy")
  `ITF_ASSERT(a_done_idle, done |-> !busy && $past(busy), "CORDIC done without a pass")

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none
module testbench;
  import itf_pkg::*;

  typedef struct packed {
    logic signed [15:0] ax, ay, az, gx, gy, gz;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] ax, ay, az;
    logic signed [19:0] gx, gy, gz;
    logic signed [15:0] pitch, roll;
    logic signed [31:0] yaw;
  } filt_out_t;

  localparam int WIN = WINDOW_LENGTH_DEF;
  localparam int STEPS = CORDIC_STEPS_DEF < CORDIC_MAX_STEPS ? CORDIC_STEPS_DEF
                                                              : CORDIC_MAX_STEPS;
  localparam int STALL_LIMIT = 8000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  sample_t drv = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] accel_x_out, accel_y_out, accel_z_out, pitch_angle, roll_angle;
  logic signed [19:0] gyro_x_out, gyro_y_out, gyro_z_out;
  logic signed [31:0] yaw_angle;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  imu_tilt_and_heading_filter u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .accel_x(drv.ax), .accel_y(drv.ay), .accel_z(drv.az),
    .gyro_x(drv.gx), .gyro_y(drv.gy), .gyro_z(drv.gz),
    .out_valid(out_valid), .out_stall(out_stall),
    .accel_x_out(accel_x_out), .accel_y_out(accel_y_out), .accel_z_out(accel_z_out),
    .gyro_x_out(gyro_x_out), .gyro_y_out(gyro_y_out), .gyro_z_out(gyro_z_out),
    .pitch_angle(pitch_angle), .roll_angle(roll_angle), .yaw_angle(yaw_angle),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Mirror of the block's settings and filter state.
  longint unsigned m_accel_alpha, m_gyro_alpha, m_yaw_step, m_accel_gain, m_gyro_gain;
  longint win_raw [3][WIN];
  int win_pos;
  longint accel_ema [3];
  longint gyro_ema [3];
  longint yaw_sum;

  sample_t pending_samples [$];
  filt_out_t expected_outputs [$];
  int error_count = 0;
  int mismatch_count = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int quiet_cycles = 0;

  function automatic longint rshift_round(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint smooth(longint s, longint x, longint unsigned alpha);
    longint a;
    a = alpha > 65536 ? 65536 : longint'(alpha);
    return (a * x + (65536 - a) * s + 32768) >>> 16;
  endfunction

  function automatic longint cordic_vec(longint x, longint y, output longint z);
    longint dx, dy;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_Q16[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_Q16[i]);
      end
    end
    return x;
  endfunction

  function automatic longint tilt_angle(longint w, longint u, longint v);
    longint m, z;
    m = cordic_vec(u < 0 ? -u : u, v, z);
    m = rshift_round(m * longint'(INV_GAIN_Q16), 16);
    if (m == 0 && w == 0) return 0;
    void'(cordic_vec(m, w, z));
    return clamp(rshift_round(z, 8), -23040, 23040);
  endfunction

  function automatic filt_out_t filter_sample(sample_t s);
    filt_out_t r;
    longint raw [3];
    longint sum, mean, g, inc;
    raw[0] = s.ax; raw[1] = s.ay; raw[2] = s.az;
    for (int a = 0; a < 3; a++) begin
      win_raw[a][win_pos] = raw[a];
      sum = 0;
      for (int i = 0; i < WIN; i++) sum += win_raw[a][i];
      mean = (sum * longint'(m_accel_gain)) / (longint'(WIN) * 256);
      mean = clamp(mean, -64'sd2147483648, 64'sd2147483647);
      accel_ema[a] = smooth(accel_ema[a], mean, m_accel_alpha);
    end
    win_pos = (win_pos + 1) % WIN;
    raw[0] = s.gx; raw[1] = s.gy; raw[2] = s.gz;
    for (int a = 0; a < 3; a++) begin
      g = raw[a] * longint'(m_gyro_gain);
      gyro_ema[a] = smooth(gyro_ema[a], g, m_gyro_alpha);
    end
    inc = rshift_round(gyro_ema[2] * longint'(m_yaw_step), 16);
    yaw_sum = clamp(yaw_sum + inc, -64'sd2147483648, 64'sd2147483647);
    r.ax = 16'(clamp(rshift_round(accel_ema[0], 6), -32768, 32767));
    r.ay = 16'(clamp(rshift_round(accel_ema[1], 6), -32768, 32767));
    r.az = 16'(clamp(rshift_round(accel_ema[2], 6), -32768, 32767));
    r.gx = 20'(clamp(rshift_round(gyro_ema[0], 4), -524288, 524287));
    r.gy = 20'(clamp(rshift_round(gyro_ema[1], 4), -524288, 524287));
    r.gz = 20'(clamp(rshift_round(gyro_ema[2], 4), -524288, 524287));
    r.pitch = 16'(tilt_angle(accel_ema[1], accel_ema[0], accel_ema[2]));
    r.roll = 16'(tilt_angle(-accel_ema[0], accel_ema[1], accel_ema[2]));
    r.yaw = 32'(yaw_sum);
    return r;
  endfunction

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_outputs.push_back(filter_sample(drv));
        samples_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          drv <= pending_samples.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    filt_out_t got, exp_r;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        got = '{accel_x_out, accel_y_out, accel_z_out, gyro_x_out, gyro_y_out,
                gyro_z_out, pitch_angle, roll_angle, yaw_angle};
        if (expected_outputs.size() == 0) begin
          error_count++;
          $display("unexpected result %p", got);
        end else begin
          exp_r = expected_outputs.pop_front();
          if (got !== exp_r) begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch at result %0d: expected %p, got %p",
                       results_seen, exp_r, got);
          end
        end
      end
      out_stall <= $urandom_range(0, 99) < rcv_idle_pct;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ACCEL_SMOOTHING: m_accel_alpha = val[16:0];
      CFG_GYRO_SMOOTHING: m_gyro_alpha = val[16:0];
      CFG_YAW_STEP: m_yaw_step = val[15:0];
      CFG_ACCEL_GAIN: m_accel_gain = val;
      CFG_GYRO_GAIN: m_gyro_gain = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [23:0] aa, logic [23:0] ga, logic [23:0] ys,
                          logic [23:0] ag, logic [23:0] gg);
    write_reg(CFG_ACCEL_SMOOTHING, aa);
    write_reg(CFG_GYRO_SMOOTHING, ga);
    write_reg(CFG_YAW_STEP, ys);
    write_reg(CFG_ACCEL_GAIN, ag);
    write_reg(CFG_GYRO_GAIN, gg);
  endtask

  function automatic logic signed [15:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 16'sd32767;
      1: return -16'sd32768;
      2: return 16'($urandom_range(0, 64)) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    return '{rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
  endfunction

  // Mostly runs of a held pose with small jitter, so the filters settle;
  // the rest is unrelated noise.
  task automatic queue_random(int count);
    sample_t base, s;
    int run;
    while (count > 0) begin
      base = rand_sample();
      run = $urandom_range(0, 3) == 0 ? 1 : $urandom_range(5, 20);
      for (int k = 0; k < run && count > 0; k++) begin
        s = base;
        if (run > 1) begin
          s.ax += 16'($urandom_range(0, 15)) - 16'sd8;
          s.ay += 16'($urandom_range(0, 15)) - 16'sd8;
          s.az += 16'($urandom_range(0, 15)) - 16'sd8;
          s.gz += 16'($urandom_range(0, 15)) - 16'sd8;
        end
        pending_samples.push_back(s);
        count--;
      end
    end
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_samples.size() > 0 || in_valid || expected_outputs.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    m_accel_alpha = ACCEL_SMOOTHING_RST;
    m_gyro_alpha = GYRO_SMOOTHING_RST;
    m_yaw_step = YAW_STEP_RST;
    m_accel_gain = ACCEL_GAIN_RST;
    m_gyro_gain = GYRO_GAIN_RST;
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < WIN; i++) win_raw[a][i] = 0;
      accel_ema[a] = 0;
      gyro_ema[a] = 0;
    end
    win_pos = 0;
    yaw_sum = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings; zero vector first, then field extremes and pose edges.
    snd_idle_pct = 17;
    rcv_idle_pct = 60;
    pending_samples.push_back('0);
    pending_samples.push_back('0);
    repeat (4) pending_samples.push_back('{16'sd32767, 16'sd32767, 16'sd32767,
                                           16'sd32767, 16'sd32767, 16'sd32767});
    repeat (4) pending_samples.push_back('{-16'sd32768, -16'sd32768, -16'sd32768,
                                           -16'sd32768, -16'sd32768, -16'sd32768});
    repeat (3) pending_samples.push_back('{16'sd0, 16'sd0, 16'sd16384,
                                           16'sd1, -16'sd1, 16'sd0});
    repeat (3) pending_samples.push_back('{16'sd16384, 16'sd0, 16'sd0,
                                           16'sd0, 16'sd0, 16'sd0});
    repeat (3) pending_samples.push_back('{-16'sd32768, 16'sd32767, 16'sd0,
                                           16'sd0, 16'sd0, 16'sd32767});
    repeat (3) pending_samples.push_back('{16'sd0, -16'sd16384, -16'sd16384,
                                           16'sd0, 16'sd0, -16'sd32768});
    queue_random(260);
    drain();

    // Unity weights and full gains: saturation of means, outputs and heading.
    set_regs(24'd65536, 24'd65536, 24'd65535, 24'd16777215, 24'd65535);
    queue_random(290);
    drain();

    snd_idle_pct = 60;
    rcv_idle_pct = 17;
    // Zero weights and gains hold the smoothed states and the heading at their last values.
    set_regs(24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    queue_random(120);
    drain();

    // Weights above one, and writes to unused indexes that must be ignored.
    set_regs(24'h1FFFF, 24'hFFFFFF, 24'd1, 24'd1, 24'd1);
    write_reg(3'd5, 24'($urandom));
    write_reg(3'd6, 24'($urandom));
    write_reg(3'd7, 24'($urandom));
    queue_random(290);
    drain();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_regs(24'($urandom_range(0, 65536)), 24'($urandom_range(0, 65536)),
             24'($urandom_range(0, 65535)), 24'($urandom_range(0, 200000)),
             24'($urandom_range(0, 65535)));
    queue_random(290);
    drain();

    set_regs(ACCEL_SMOOTHING_RST, GYRO_SMOOTHING_RST, YAW_STEP_RST, ACCEL_GAIN_RST,
             GYRO_GAIN_RST);
    queue_random(290);
    drain();

    $display("Sent %0d samples over six register settings, checked %0d results.",
             samples_sent, results_seen);
    $display("Mismatches: %0d, total errors: %0d.", mismatch_count, error_count);
    if (error_count == 0 && expected_outputs.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
+incdir+hw/rtl
hw/rtl/itf_pkg.sv
hw/rtl/itf_mul.sv
hw/rtl/itf_cordic.sv
hw/rtl/imu_tilt_and_heading_filter.sv
verif/testbench.sv
